### design/wifi_mgmt_frame_sniffer_macros.svh
// Assertion macros shared by the sniffer RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef WIFI_MGMT_FRAME_SNIFFER_MACROS_SVH
`define WIFI_MGMT_FRAME_SNIFFER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WMFS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wmfs assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define WMFS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wmfs assertion failed");

`endif

### design/wmfs_pkg.sv
`timescale 1ns / 1ps

package wmfs_pkg;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam logic [7:0] CODE_PROBE  = 8'h40;
  localparam logic [7:0] CODE_DEAUTH = 8'hC0;

  localparam logic [1:0] CLS_OTHER  = 2'd0;
  localparam logic [1:0] CLS_DEAUTH = 2'd1;
  localparam logic [1:0] CLS_PROBE  = 2'd2;

  localparam int unsigned SSID_LIMIT      = 33;
  localparam int unsigned SSID_START      = 26;
  localparam int unsigned SSID_MAX        = 32;
  localparam int unsigned HASH_FIRST_POS  = 10;
  localparam int unsigned HASH_LAST_POS   = 15;
  localparam int unsigned TAG_POS         = 24;
  localparam int unsigned LEN_POS         = 25;
  localparam int unsigned PROBE_MIN_BYTES = 16;

  typedef struct packed {
    logic start;
    logic write;
  } walk_req_t;

  typedef struct packed {
    logic done;
    logic busy;
  } walk_rsp_t;

endpackage

### design/wmfs_in_if.sv
`timescale 1ns / 1ps

interface wmfs_in_if;
  logic              valid;
  logic              ready;
  logic [7:0]        frame_byte;
  logic              is_management;
  logic signed [7:0] signal_strength;
  logic [11:0]       frame_length;
  logic [31:0]       time_ms;
  logic              end_of_frame;
  logic              clear_deauth;

  modport source (
    output valid, frame_byte, is_management, signal_strength, frame_length, time_ms,
           end_of_frame, clear_deauth,
    input  ready
  );

  modport sink (
    input  valid, frame_byte, is_management, signal_strength, frame_length, time_ms,
           end_of_frame, clear_deauth,
    output ready
  );
endinterface

### design/wmfs_out_if.sv
`timescale 1ns / 1ps

interface wmfs_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        frame_class;
  logic [31:0]       source_hash;
  logic signed [7:0] rssi_out;
  logic [31:0]       stamp_ms;
  logic [5:0]        ssid_length;
  logic [3:0]        slot;
  logic [31:0]       deauth_total;
  logic [4:0]        probe_total;
  logic [4:0]        unique_sources;
  logic [7:0]        ssid_byte;
  logic [4:0]        ssid_index;
  logic              last_of_run;

  modport source (
    output valid, frame_class, source_hash, rssi_out, stamp_ms, ssid_length, slot,
           deauth_total, probe_total, unique_sources, ssid_byte, ssid_index, last_of_run,
    input  ready
  );

  modport sink (
    input  valid, frame_class, source_hash, rssi_out, stamp_ms, ssid_length, slot,
           deauth_total, probe_total, unique_sources, ssid_byte, ssid_index, last_of_run,
    output ready
  );
endinterface

### design/wmfs_uniq.sv
`timescale 1ns / 1ps

`include "wifi_mgmt_frame_sniffer_macros.svh"

module wmfs_uniq #(
  parameter int RING_DEPTH = 16,
  localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1,
  localparam int CNT_W = $clog2(RING_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  wmfs_pkg::walk_req_t req,
  input  logic [IDX_W-1:0]   wr_slot,
  input  logic [31:0]        wr_hash,
  input  logic [CNT_W-1:0]   held,
  output wmfs_pkg::walk_rsp_t rsp,
  output logic [CNT_W-1:0]   uniq
);
  import wmfs_pkg::*;

  typedef enum logic [2:0] {
    U_IDLE,
    U_LOADI,
    U_CAND,
    U_SCAN,
    U_DONE
  } ustate_t;

  ustate_t          state_r;
  logic [31:0]      ring_mem [RING_DEPTH];
  logic [31:0]      mem_q_r;
  logic [31:0]      cand_r;
  logic [IDX_W-1:0] i_r;
  logic [IDX_W-1:0] j_r;
  logic [IDX_W-1:0] rd_addr;
  logic [CNT_W-1:0] held_r;
  logic [CNT_W-1:0] cnt_r;
  logic             last_i;

  assign last_i = (CNT_W'(i_r) + CNT_W'(1)) == held_r;
  assign rsp.done = (state_r == U_DONE);
  assign rsp.busy = (state_r != U_IDLE);
  assign uniq = cnt_r;

  always_comb begin
    unique case (state_r)
      U_CAND:  rd_addr = '0;
      U_SCAN:  rd_addr = j_r + IDX_W'(1);
      default: rd_addr = i_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (req.start && req.write) begin
      ring_mem[wr_slot] <= wr_hash;
    end
    mem_q_r <= ring_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      held_r  <= '0;
      cnt_r   <= '0;
      i_r     <= '0;
    end else begin
      unique case (state_r)
        U_IDLE: begin
          if (req.start) begin
            held_r  <= held;
            cnt_r   <= '0;
            i_r     <= '0;
            state_r <= (held == '0) ? U_DONE : U_LOADI;
          end
        end
        U_LOADI: begin
          state_r <= U_CAND;
        end
        U_CAND: begin
          cand_r <= mem_q_r;
          j_r    <= '0;
          if (i_r == '0) begin
            cnt_r <= cnt_r + CNT_W'(1);
            if (last_i) begin
              state_r <= U_DONE;
            end else begin
              i_r     <= i_r + IDX_W'(1);
              state_r <= U_LOADI;
            end
          end else begin
            state_r <= U_SCAN;
          end
        end
        U_SCAN: begin
          if (mem_q_r == cand_r || j_r == i_r - IDX_W'(1)) begin
            if (mem_q_r != cand_r) begin
              cnt_r <= cnt_r + CNT_W'(1);
            end
            if (last_i) begin
              state_r <= U_DONE;
            end else begin
              i_r     <= i_r + IDX_W'(1);
              state_r <= U_LOADI;
            end
          end else begin
            j_r <= j_r + IDX_W'(1);
          end
        end
        U_DONE: begin
          state_r <= U_IDLE;
        end
        default: begin
          state_r <= U_IDLE;
        end
      endcase
    end
  end

  `WMFS_ASSERT_IMP(a_start_when_idle, req.start, !rsp.busy)
  `WMFS_ASSERT_IMP(a_count_bounded, 1'b1, cnt_r <= held_r)
  `WMFS_ASSERT_IMP(a_scan_below_cand, state_r == U_SCAN, j_r < i_r)
  `WMFS_ASSERT_NXT(a_done_single, rsp.done, !rsp.done)

endmodule

### design/wifi_mgmt_frame_sniffer.sv
`timescale 1ns / 1ps

`include "wifi_mgmt_frame_sniffer_macros.svh"

// Frame bytes arrive on in_ch, one byte per transfer, starting at byte zero of a frame.
// Metadata and the frame class are taken from the first byte; end_of_frame marks the last.
// A byte that is not the last one produces no result.
// After the last byte the block records a probe hash in the hash ring, then counts the
// distinct hashes held in the ring by comparing each entry with all earlier entries
// through one comparator and one ring read port. The record transfer is offered once the
// count is done, and each SSID byte transfer is offered after the previous one is taken.
// No input transfer is taken from the last byte of a frame until its final result
// has been transferred on out_ch; a stalled out_ch simply holds the current result.
// The capture enable is written through cfg_wr_en and cfg_wr_data; the user must
// write it only while the block is idle, which the block itself does not enforce.
// Reset clears the counters, the byte position and the ring fill state; ring and SSID
// contents are not cleared, since only written entries are ever read.
module wifi_mgmt_frame_sniffer #(
  parameter int RING_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  wmfs_in_if.sink    in_ch,
  wmfs_out_if.source out_ch,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);
  import wmfs_pkg::*;

  localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W = $clog2(RING_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_WALK,
    S_WAIT,
    S_SBYTE
  } state_t;

  state_t            state_r;
  logic              cap_en_r;
  logic [11:0]       bpos_r;
  logic [31:0]       hash_r;
  logic [1:0]        cls_r;
  logic signed [7:0] rssi_r;
  logic [11:0]       flen_r;
  logic [31:0]       tms_r;
  logic [7:0]        tag_r;
  logic [7:0]        slen_r;
  logic [12:0]       rcv_r;
  logic [31:0]       deauth_r;
  logic [31:0]       pw_r;
  logic [IDX_W-1:0]  wp_r;
  logic [CNT_W-1:0]  held_r;
  logic [4:0]        nb_r;
  logic [7:0]        ssid_mem [SSID_MAX];
  logic [7:0]        ssid_q_r;

  logic              out_valid_r;
  logic [1:0]        o_cls_r;
  logic [31:0]       o_hash_r;
  logic signed [7:0] o_rssi_r;
  logic [31:0]       o_stamp_r;
  logic [5:0]        o_slen_r;
  logic [3:0]        o_slot_r;
  logic [31:0]       o_deauth_r;
  logic [4:0]        o_total_r;
  logic [4:0]        o_uniq_r;
  logic [7:0]        o_byte_r;
  logic [4:0]        o_index_r;
  logic              o_last_r;

  logic              in_acc;
  logic              first;
  logic [7:0]        fb;
  logic [1:0]        cls_cur;
  logic [31:0]       deauth_base;
  logic [31:0]       deauth_nxt;
  logic [31:0]       hash_base;
  logic [31:0]       hash_mix;
  logic [31:0]       hash_prod;
  logic [31:0]       hash_nxt;
  logic [7:0]        tag_nxt;
  logic [7:0]        slen_nxt;
  logic              ssid_we;
  logic [4:0]        ssid_wa;

  logic              is_probe;
  logic [12:0]       ssid_end;
  logic              ssid_ok;
  logic [CNT_W-1:0]  held_new;
  logic [31:0]       wp_ext;
  logic [31:0]       held_ext;
  logic [31:0]       uniq_ext;
  logic [5:0]        rec_slen;
  logic              non_probe_out;

  walk_req_t         walk_req;
  walk_rsp_t         walk_rsp;
  logic [CNT_W-1:0]  walk_uniq;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc = in_ch.valid && in_ch.ready;
  assign fb = in_ch.frame_byte;
  assign first = (bpos_r == '0);

  always_comb begin
    cls_cur = cls_r;
    if (first) begin
      cls_cur = CLS_OTHER;
      if (cap_en_r && in_ch.is_management) begin
        if (fb == CODE_DEAUTH) begin
          cls_cur = CLS_DEAUTH;
        end else if (fb == CODE_PROBE) begin
          cls_cur = CLS_PROBE;
        end
      end
    end

    deauth_base = in_ch.clear_deauth ? '0 : deauth_r;
    deauth_nxt = deauth_base;
    if (first && cls_cur == CLS_DEAUTH && deauth_base != '1) begin
      deauth_nxt = deauth_base + 32'd1;
    end

    hash_base = first ? FNV_BASIS : hash_r;
    hash_mix = hash_base ^ {24'd0, fb};
    hash_prod = hash_mix * FNV_PRIME;
    hash_nxt = hash_base;
    if (cls_cur == CLS_PROBE && bpos_r >= 12'(HASH_FIRST_POS)
        && bpos_r <= 12'(HASH_LAST_POS)) begin
      hash_nxt = hash_prod;
    end

    tag_nxt = first ? 8'd0 : tag_r;
    slen_nxt = first ? 8'd0 : slen_r;
    if (cls_cur == CLS_PROBE && bpos_r == 12'(TAG_POS)) begin
      tag_nxt = fb;
    end
    if (cls_cur == CLS_PROBE && bpos_r == 12'(LEN_POS)) begin
      slen_nxt = fb;
    end

    ssid_we = (cls_cur == CLS_PROBE) && (bpos_r >= 12'(SSID_START))
              && (bpos_r < 12'(SSID_START + SSID_MAX));
    ssid_wa = 5'(bpos_r - 12'(SSID_START));
  end

  always_comb begin
    is_probe = (cls_r == CLS_PROBE) && (rcv_r >= 13'(PROBE_MIN_BYTES));
    ssid_end = 13'(slen_r) + 13'(SSID_START);
    ssid_ok = (flen_r > 12'(SSID_START)) && (tag_r == 8'd0) && (slen_r != 8'd0)
              && (slen_r < 8'(SSID_LIMIT)) && (ssid_end <= 13'(flen_r))
              && (ssid_end <= rcv_r);
    held_new = held_r;
    if (is_probe && held_r != CNT_W'(RING_DEPTH)) begin
      held_new = held_r + CNT_W'(1);
    end
    wp_ext = 32'(wp_r);
    held_ext = 32'(held_new);
    uniq_ext = 32'(walk_uniq);
    rec_slen = (is_probe && ssid_ok) ? slen_r[5:0] : 6'd0;
  end

  assign walk_req.start = (state_r == S_WRITE);
  assign walk_req.write = is_probe;

  wmfs_uniq #(
    .RING_DEPTH(RING_DEPTH)
  ) u_uniq (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (walk_req),
    .wr_slot (wp_r),
    .wr_hash (hash_r),
    .held    (held_new),
    .rsp     (walk_rsp),
    .uniq    (walk_uniq)
  );

  always_ff @(posedge clk) begin
    if (in_acc && ssid_we) begin
      ssid_mem[ssid_wa] <= fb;
    end
    ssid_q_r <= ssid_mem[nb_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_en_r    <= 1'b0;
      bpos_r      <= '0;
      cls_r       <= CLS_OTHER;
      deauth_r    <= '0;
      pw_r        <= '0;
      wp_r        <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_en_r <= cfg_wr_data;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (first) begin
              rssi_r <= in_ch.signal_strength;
              flen_r <= in_ch.frame_length;
              tms_r  <= in_ch.time_ms;
            end
            cls_r    <= cls_cur;
            deauth_r <= deauth_nxt;
            hash_r   <= hash_nxt;
            tag_r    <= tag_nxt;
            slen_r   <= slen_nxt;
            if (in_ch.end_of_frame) begin
              bpos_r  <= '0;
              rcv_r   <= 13'(bpos_r) + 13'd1;
              state_r <= S_WRITE;
            end else if (bpos_r != '1) begin
              bpos_r <= bpos_r + 12'd1;
            end
          end
        end
        S_WRITE: begin
          o_cls_r    <= is_probe ? CLS_PROBE : ((cls_r == CLS_PROBE) ? CLS_OTHER : cls_r);
          o_hash_r   <= is_probe ? hash_r : 32'd0;
          o_rssi_r   <= is_probe ? rssi_r : 8'sd0;
          o_stamp_r  <= is_probe ? tms_r : 32'd0;
          o_slen_r   <= rec_slen;
          o_slot_r   <= is_probe ? wp_ext[3:0] : 4'd0;
          o_deauth_r <= deauth_r;
          o_total_r  <= held_ext[4:0];
          o_byte_r   <= 8'd0;
          o_index_r  <= 5'd0;
          o_last_r   <= (rec_slen == 6'd0);
          nb_r       <= '0;
          held_r     <= held_new;
          if (is_probe) begin
            if (pw_r == '1) begin
              pw_r <= 32'(RING_DEPTH);
              wp_r <= '0;
            end else begin
              pw_r <= pw_r + 32'd1;
              wp_r <= (wp_r == IDX_W'(RING_DEPTH - 1)) ? '0 : wp_r + IDX_W'(1);
            end
          end
          state_r <= S_WALK;
        end
        S_WALK: begin
          if (walk_rsp.done) begin
            o_uniq_r    <= uniq_ext[4:0];
            out_valid_r <= 1'b1;
            state_r     <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (out_ch.ready) begin
            out_valid_r <= 1'b0;
            state_r     <= o_last_r ? S_IDLE : S_SBYTE;
          end
        end
        S_SBYTE: begin
          o_byte_r    <= ssid_q_r;
          o_index_r   <= nb_r;
          o_last_r    <= (6'(nb_r) + 6'd1) == o_slen_r;
          nb_r        <= nb_r + 5'd1;
          out_valid_r <= 1'b1;
          state_r     <= S_WAIT;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.frame_class    = o_cls_r;
  assign out_ch.source_hash    = o_hash_r;
  assign out_ch.rssi_out       = o_rssi_r;
  assign out_ch.stamp_ms       = o_stamp_r;
  assign out_ch.ssid_length    = o_slen_r;
  assign out_ch.slot           = o_slot_r;
  assign out_ch.deauth_total   = o_deauth_r;
  assign out_ch.probe_total    = o_total_r;
  assign out_ch.unique_sources = o_uniq_r;
  assign out_ch.ssid_byte      = o_byte_r;
  assign out_ch.ssid_index     = o_index_r;
  assign out_ch.last_of_run    = o_last_r;

  assign non_probe_out = out_valid_r && (o_cls_r != CLS_PROBE);

  `WMFS_ASSERT_IMP(a_no_input_while_result, out_ch.valid, !in_ch.ready)
  `WMFS_ASSERT_IMP(a_more_needs_ssid, out_valid_r && !o_last_r, o_slen_r != 6'd0)
  `WMFS_ASSERT_IMP(a_non_probe_empty, non_probe_out, o_hash_r == '0 && o_slen_r == '0)

endmodule
